[src/rclfp_pkg.sv]
// Shared constants and the CRC-8 step function for the RC link frame parser.
package rclfp_pkg;

  // Frame format limits.
  localparam int unsigned MAX_FRAME_LEN = 64;
  localparam int unsigned LEN_W         = 7;
  localparam int unsigned STORE_DEPTH   = 22;
  localparam int unsigned STORE_ADDR_W  = $clog2(STORE_DEPTH);

  // Channel unpacking.
  localparam int unsigned NUM_CHANNELS  = 16;
  localparam int unsigned CHAN_IDX_W    = $clog2(NUM_CHANNELS);
  localparam int unsigned CHAN_W        = 11;

  // Protocol bytes.
  localparam logic [7:0] SYNC_BYTE     = 8'hC8;
  localparam logic [7:0] CRC_POLY      = 8'hD5;
  localparam logic [7:0] TYPE_CHANNELS = 8'h16;
  localparam logic [7:0] TYPE_STATS    = 8'h14;

  // Minimum frame lengths (type and CRC bytes included).
  localparam logic [LEN_W-1:0] CHAN_LEN_MIN  = LEN_W'(22 + 2);
  localparam logic [LEN_W-1:0] STATS_LEN_MIN = LEN_W'(10 + 2);

  // Reset values.
  localparam logic [15:0]       TIMEOUT_RESET = 16'd1000;
  localparam logic signed [8:0] RSSI_RESET    = -9'sd100;

  // One byte of CRC-8, MSB first, over an eight step shift.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[src/rc_link_frame_parser_top.sv]
// Top level of the RC link frame parser: frame hunter, CRC check and result sequencer.
// An input beat passes the input register and then the result register before its first result.
// Throughput: one input beat per cycle while results are taken; a channel frame ends in a burst of 16 result beats,
// during which one more input beat is held and further input waits for the final beat.
// Reset: synchronous, active low; timeout returns to 1000 ticks, failsafe is set, held RSSI
// is -100; the payload store is not cleared.
module rc_link_frame_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] operation
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [3:0] channel_index, [14:4] channel_value,
                                  // [23:15] rssi, [31:24] lq,
                                  // [39:32] snr, [40] failsafe, [47:41] zero
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  output logic        out_tlast,
  // Configuration write: failsafe_timeout.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import rclfp_pkg::*;

  localparam logic [1:0] PH_SYNC = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  localparam logic [1:0] EV_CHANNEL  = 2'd0;
  localparam logic [1:0] EV_STATS    = 2'd1;
  localparam logic [1:0] EV_FAILSAFE = 2'd2;

  localparam logic OP_TICK = 1'b1;

  // Input register.
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_op_r;
  logic [7:0] s1_byte_r;

  // Frame state.
  logic [1:0]       phase_r, phase_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       store_r [STORE_DEPTH];
  logic [STORE_DEPTH*8-1:0] store_bits;
  logic             store_we;
  logic [STORE_ADDR_W-1:0] store_addr;

  // Held link values and failsafe tracking.
  logic signed [8:0] rssi_r, rssi_nxt;
  logic [7:0]        quality_r, quality_nxt;
  logic [7:0]        snr_r, snr_nxt;
  logic              failsafe_r, failsafe_nxt;
  logic [15:0]       ticks_r, ticks_nxt;
  logic [15:0]       ticks_inc;
  logic [15:0]       timeout_r;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_kind_r, out_kind_nxt;
  logic [CHAN_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [CHAN_W-1:0]     chan_value;

  logic proc_en;
  logic s1_go;
  logic out_adv;

  // A new item may be processed once no result beat is pending, or the final beat is being taken.
  assign proc_en   = !out_valid_r || (out_tready && out_last_r);
  assign s1_go     = s1_valid_r && proc_en;
  assign in_tready = !s1_valid_r || proc_en;
  assign out_adv   = out_valid_r && out_tready && !out_last_r;
  assign cfg_ready = 1'b1;
  assign ticks_inc = (ticks_r != 16'hFFFF) ? (ticks_r + 16'd1) : ticks_r;

  // Flatten the payload store for channel extraction.
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      store_bits[i*8 +: 8] = store_r[i];
    end
  end

  rclfp_chan_sel u_chan_sel (
    .store_bits (store_bits),
    .chan_idx   (out_idx_r),
    .chan_value (chan_value)
  );

  // Input register handshake.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Frame hunter, CRC check, tick counter and result loading.
  always_comb begin
    phase_nxt     = phase_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    type_nxt      = type_r;
    rssi_nxt      = rssi_r;
    quality_nxt   = quality_r;
    snr_nxt       = snr_r;
    failsafe_nxt  = failsafe_r;
    ticks_nxt     = ticks_r;
    store_we      = 1'b0;
    store_addr    = STORE_ADDR_W'(cnt_r - LEN_W'(1));
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;

    // Step through a channel burst, or retire the final beat.
    if (out_adv) begin
      out_idx_nxt  = out_idx_r + CHAN_IDX_W'(1);
      out_last_nxt = (out_idx_r == CHAN_IDX_W'(NUM_CHANNELS - 2));
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (s1_go) begin
      if (s1_op_r == OP_TICK) begin
        ticks_nxt = ticks_inc;
        if ((ticks_inc > timeout_r) && !failsafe_r) begin
          failsafe_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = EV_FAILSAFE;
          out_idx_nxt   = '0;
          out_last_nxt  = 1'b1;
        end
      end else begin
        unique case (phase_r)
          PH_LEN: begin
            if ((s1_byte_r >= 8'd2) && (s1_byte_r <= 8'(MAX_FRAME_LEN))) begin
              len_nxt   = s1_byte_r[LEN_W-1:0];
              cnt_nxt   = '0;
              crc_nxt   = '0;
              phase_nxt = PH_DATA;
            end else begin
              phase_nxt = PH_SYNC;
            end
          end
          PH_DATA: begin
            if (({1'b0, cnt_r} + 8'd1) >= {1'b0, len_r}) begin
              // Final byte is the CRC.
              phase_nxt = PH_SYNC;
              if (crc_r == s1_byte_r) begin
                if ((type_r == TYPE_CHANNELS) && (len_r >= CHAN_LEN_MIN)) begin
                  failsafe_nxt  = 1'b0;
                  ticks_nxt     = '0;
                  out_valid_nxt = 1'b1;
                  out_kind_nxt  = EV_CHANNEL;
                  out_idx_nxt   = '0;
                  out_last_nxt  = 1'b0;
                end else if ((type_r == TYPE_STATS) && (len_r >= STATS_LEN_MIN)) begin
                  rssi_nxt      = -$signed({store_r[0][7], store_r[0]});
                  quality_nxt   = store_r[2];
                  snr_nxt       = store_r[3];
                  out_valid_nxt = 1'b1;
                  out_kind_nxt  = EV_STATS;
                  out_idx_nxt   = '0;
                  out_last_nxt  = 1'b1;
                end
              end
            end else begin
              crc_nxt = crc8_step(crc_r, s1_byte_r);
              if (cnt_r == '0) begin
                type_nxt = s1_byte_r;
              end else if (cnt_r <= LEN_W'(STORE_DEPTH)) begin
                store_we = 1'b1;
              end
              cnt_nxt = cnt_r + LEN_W'(1);
            end
          end
          default: begin
            // Sync hunt; the unused phase code behaves the same way.
            phase_nxt = (s1_byte_r == SYNC_BYTE) ? PH_LEN : PH_SYNC;
          end
        endcase
      end
    end
  end

  // Control and held-state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_SYNC;
      len_r       <= '0;
      cnt_r       <= '0;
      crc_r       <= '0;
      type_r      <= '0;
      rssi_r      <= RSSI_RESET;
      quality_r   <= '0;
      snr_r       <= '0;
      failsafe_r  <= 1'b1;
      ticks_r     <= '0;
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
      out_kind_r  <= EV_CHANNEL;
      out_idx_r   <= '0;
      out_last_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      type_r      <= type_nxt;
      rssi_r      <= rssi_nxt;
      quality_r   <= quality_nxt;
      snr_r       <= snr_nxt;
      failsafe_r  <= failsafe_nxt;
      ticks_r     <= ticks_nxt;
      out_valid_r <= out_valid_nxt;
      out_kind_r  <= out_kind_nxt;
      out_idx_r   <= out_idx_nxt;
      out_last_r  <= out_last_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= in_tuser[0];
      s1_byte_r <= in_tdata;
    end
  end

  // Payload store, written one byte per beat.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[store_addr] <= s1_byte_r;
    end
  end

  // Result beat assembly.
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'd0,
                       failsafe_r,
                       snr_r,
                       quality_r,
                       rssi_r,
                       (out_kind_r == EV_CHANNEL) ? chan_value : CHAN_W'(0),
                       (out_kind_r == EV_CHANNEL) ? out_idx_r : CHAN_IDX_W'(0)};

endmodule

[src/rclfp_chan_sel.sv]
// Picks one 11-bit channel out of the packed channel payload bits.
module rclfp_chan_sel (
  input  logic [rclfp_pkg::STORE_DEPTH*8-1:0] store_bits,
  input  logic [rclfp_pkg::CHAN_IDX_W-1:0]    chan_idx,
  output logic [rclfp_pkg::CHAN_W-1:0]        chan_value
);
  import rclfp_pkg::*;

  // Channels sit back to back, LSB first; each one is at a fixed bit offset.
  always_comb begin
    chan_value = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (chan_idx == CHAN_IDX_W'(i)) begin
        chan_value = store_bits[i*CHAN_W +: CHAN_W];
      end
    end
  end

endmodule
